// ===== src/bspr_pkg.sv =====
package bspr_pkg;

   // antenna count, 1 to 4
   localparam int ANTENNAS = 4;
   // calibration registers that the csr port always provides
   localparam int NUM_CAL = 4;
   localparam logic [1:0] ANT_LAST = 2'(ANTENNAS - 1);

   // a quarter turn in 1/65536 turn units
   localparam logic [14:0] QUARTER = 15'd16384;

   // quarter-wave sine, scaled by 32768
   localparam logic [15:0] SINE_QUARTER [0:64] = '{
          16'd0,   16'd804,  16'd1608,  16'd2411,  16'd3212,  16'd4011,  16'd4808,  16'd5602,
       16'd6393,  16'd7180,  16'd7962,  16'd8740,  16'd9512, 16'd10279, 16'd11039, 16'd11793,
      16'd12540, 16'd13279, 16'd14010, 16'd14733, 16'd15447, 16'd16151, 16'd16846, 16'd17531,
      16'd18205, 16'd18868, 16'd19520, 16'd20160, 16'd20788, 16'd21403, 16'd22006, 16'd22595,
      16'd23170, 16'd23732, 16'd24279, 16'd24812, 16'd25330, 16'd25833, 16'd26320, 16'd26791,
      16'd27246, 16'd27684, 16'd28106, 16'd28511, 16'd28899, 16'd29269, 16'd29622, 16'd29957,
      16'd30274, 16'd30572, 16'd30853, 16'd31114, 16'd31357, 16'd31581, 16'd31786, 16'd31972,
      16'd32138, 16'd32286, 16'd32413, 16'd32522, 16'd32610, 16'd32679, 16'd32729, 16'd32758,
      16'd32768
   };

   // one antenna slot handed from the issue logic to the datapath
   typedef struct packed {
      logic [1:0]         ant;
      logic               last;
      logic [15:0]        cal;
      logic [15:0]        step;
      logic signed [15:0] sample_i;
      logic signed [15:0] sample_q;
   } issue_type;

   // tag that rides along with each antenna slot
   typedef struct packed {
      logic [1:0] ant;
      logic       last;
   } tag_type;

   // sine of a 16-bit turn fraction, scaled by 32768, linear interpolation
   function automatic logic signed [16:0] turn_sine(input logic [15:0] ph);
      logic [13:0] r;
      logic [14:0] x;
      logic [6:0]  idx;
      logic [7:0]  frac;
      logic [15:0] lo;
      logic [15:0] hi;
      logic [15:0] diff;
      logic [23:0] prod;
      logic [16:0] v;
      r    = ph[13:0];
      x    = ph[14] ? (QUARTER - {1'b0, r}) : {1'b0, r};
      idx  = x[14:8];
      frac = x[7:0];
      lo   = '0;
      hi   = '0;
      diff = '0;
      prod = '0;
      if (idx >= 7'd64) begin
         v = 17'(SINE_QUARTER[64]);
      end else begin
         lo   = SINE_QUARTER[idx];
         hi   = SINE_QUARTER[idx + 7'd1];
         diff = hi - lo;
         prod = 24'(diff) * 24'(frac) + 24'd128;
         v    = 17'(lo) + 17'(prod[23:8]);
      end
      return ph[15] ? (17'sd0 - $signed(v)) : $signed(v);
   endfunction

endpackage

// ===== src/bspr_datapath.sv =====
module bspr_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 issue_valid,
   input  bspr_pkg::issue_type  issue_data,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_antenna,
   output logic signed [15:0]   rsp_out_i,
   output logic signed [15:0]   rsp_out_q,
   output logic                 rsp_clipped,
   output logic                 rsp_last_antenna
);
   import bspr_pkg::*;

   // divide by 32768, round half away from zero, saturate; returns {clip, value}
   function automatic logic [16:0] round_sat(input logic signed [33:0] x);
      logic        neg;
      logic [32:0] mag;
      logic [32:0] rsum;
      logic [17:0] r;
      logic        clip;
      logic [15:0] val;
      neg  = x[33];
      mag  = neg ? 33'(34'sd0 - x) : 33'(x);
      rsum = mag + 33'd16384;
      r    = rsum[32:15];
      if (!neg) begin
         clip = (r > 18'd32767);
         val  = clip ? 16'h7fff : r[15:0];
      end else begin
         clip = (r > 18'd32768);
         val  = clip ? 16'h8000 : (16'd0 - r[15:0]);
      end
      return {clip, val};
   endfunction

   // stage 1: phase
   logic               s1_valid_ff;
   tag_type            s1_tag_ff;
   logic signed [15:0] s1_i_ff, s1_q_ff;
   logic [15:0]        s1_phase_ff;
   logic [15:0]        s1_phase_in;

   // stage 2: sine and cosine
   logic               s2_valid_ff;
   tag_type            s2_tag_ff;
   logic signed [15:0] s2_i_ff, s2_q_ff;
   logic signed [16:0] s2_sin_ff, s2_cos_ff;
   logic signed [16:0] s2_sin_in, s2_cos_in;

   // stage 3: products
   logic               s3_valid_ff;
   tag_type            s3_tag_ff;
   logic signed [32:0] s3_ic_ff, s3_qs_ff, s3_is_ff, s3_qc_ff;
   logic signed [32:0] s3_ic_in, s3_qs_in, s3_is_in, s3_qc_in;

   // stage 4: sums
   logic               s4_valid_ff;
   tag_type            s4_tag_ff;
   logic signed [33:0] s4_sum_i_ff, s4_sum_q_ff;
   logic signed [33:0] s4_sum_i_in, s4_sum_q_in;

   // output register
   logic               out_valid_ff;
   tag_type            out_tag_ff;
   logic [15:0]        out_i_ff, out_q_ff;
   logic               out_clip_ff;
   logic [16:0]        rs_i_in, rs_q_in;

   always_comb begin
      s1_phase_in = issue_data.cal - issue_data.step;
      s2_sin_in   = turn_sine(s1_phase_ff);
      s2_cos_in   = turn_sine(s1_phase_ff + 16'(QUARTER));
      s3_ic_in    = 33'(s2_i_ff) * 33'(s2_cos_ff);
      s3_qs_in    = 33'(s2_q_ff) * 33'(s2_sin_ff);
      s3_is_in    = 33'(s2_i_ff) * 33'(s2_sin_ff);
      s3_qc_in    = 33'(s2_q_ff) * 33'(s2_cos_ff);
      s4_sum_i_in = 34'(s3_ic_ff) - 34'(s3_qs_ff);
      s4_sum_q_in = 34'(s3_is_ff) + 34'(s3_qc_ff);
      rs_i_in     = round_sat(s4_sum_i_ff);
      rs_q_in     = round_sat(s4_sum_q_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= issue_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         out_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_tag_ff   <= '{ant: issue_data.ant, last: issue_data.last};
         s1_i_ff     <= issue_data.sample_i;
         s1_q_ff     <= issue_data.sample_q;
         s1_phase_ff <= s1_phase_in;

         s2_tag_ff <= s1_tag_ff;
         s2_i_ff   <= s1_i_ff;
         s2_q_ff   <= s1_q_ff;
         s2_sin_ff <= s2_sin_in;
         s2_cos_ff <= s2_cos_in;

         s3_tag_ff <= s2_tag_ff;
         s3_ic_ff  <= s3_ic_in;
         s3_qs_ff  <= s3_qs_in;
         s3_is_ff  <= s3_is_in;
         s3_qc_ff  <= s3_qc_in;

         s4_tag_ff   <= s3_tag_ff;
         s4_sum_i_ff <= s4_sum_i_in;
         s4_sum_q_ff <= s4_sum_q_in;

         out_tag_ff  <= s4_tag_ff;
         out_i_ff    <= rs_i_in[15:0];
         out_q_ff    <= rs_q_in[15:0];
         out_clip_ff <= rs_i_in[16] | rs_q_in[16];
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_antenna      = out_tag_ff.ant;
   assign rsp_out_i        = $signed(out_i_ff);
   assign rsp_out_q        = $signed(out_q_ff);
   assign rsp_clipped      = out_clip_ff;
   assign rsp_last_antenna = out_tag_ff.last;

   // a stalled pipeline keeps its stage 1, stage 4 and output slots in place
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(s1_valid_ff) && $stable(s4_valid_ff) && $stable(out_valid_ff))
      else $error("pipeline moved during stall");

   // a slot in stage 4 reaches the output on the next advance
   a_s4_to_out: assert property (@(posedge clock) disable iff (reset)
      advance && s4_valid_ff |=> out_valid_ff)
      else $error("slot lost between stage 4 and output");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !s1_valid_ff && !s2_valid_ff && !s3_valid_ff && !out_valid_ff)
      else $error("pipeline not empty after reset");

endmodule

// ===== src/beam_steer_phase_rotator_core.sv =====
// path: an accepted input transaction goes through the hold slot, the phase, sine, product
// and sum stages and the output register; its antenna results follow one per cycle
// throughput: one result per cycle unless rsp_ready stalls the output, one input sample per
// ANTENNAS (4) results, set by the single phase-rotation pipeline that serves all antennas in turn
// a steer_angle write holds req_ready low while the steering step settles
// reset (synchronous): control and configuration registers clear to zero, pipeline empties, no transaction pending
module beam_steer_phase_rotator_core (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [15:0]  req_sample_i,
   input  logic signed [15:0]  req_sample_q,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_antenna,
   output logic signed [15:0]  rsp_out_i,
   output logic signed [15:0]  rsp_out_q,
   output logic                rsp_clipped,
   output logic                rsp_last_antenna,

   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [15:0]         csr_data
);
   import bspr_pkg::*;

   // register map
   localparam logic [2:0] CSR_STEER_ANGLE = 3'd0;
   localparam logic [2:0] CSR_CAL_PHASE_0 = 3'd1;
   localparam logic [2:0] CSR_CAL_PHASE_3 = 3'd4;

   // ceil(2^32 / 360): exact floor division by 360 for numerators below 2^24
   localparam logic [23:0] RECIP_360 = 24'd11930465;
   // cycles from a steer write until the per-antenna steps are valid
   localparam logic [1:0] STEER_SETTLE = 2'd3;

   // configuration registers
   logic signed [7:0] steer_ff;
   logic [15:0]       cal_ff [NUM_CAL];

   // steering step pipeline: angle -> turn -> sine -> n * sine
   logic              turn_neg_ff;
   logic [15:0]       turn_mag_ff;
   logic signed [16:0] s_ang_ff;
   logic [15:0]       step_ff [NUM_CAL];
   logic [1:0]        busy_ff, busy_in;

   logic [7:0]        steer_mag;
   logic [23:0]       turn_num;
   logic [47:0]       turn_prod;
   logic [15:0]       turn_signed;
   logic [2:0]        cal_sel;

   // input holding slot and antenna sequencer
   logic              hold_valid_ff, hold_valid_in;
   logic signed [15:0] hold_i_ff, hold_q_ff;
   logic [1:0]        ant_ff, ant_in;

   logic              advance;
   logic              last_issue;
   logic              issue_fire;
   logic              req_fire;
   logic              csr_fire;
   logic              steer_write;
   issue_type         issue_data;

   assign csr_ready   = 1'b1;
   assign csr_fire    = csr_valid && csr_ready;
   assign steer_write = csr_fire && (csr_index == CSR_STEER_ANGLE);
   assign cal_sel     = csr_index - CSR_CAL_PHASE_0;

   // whole pipeline moves unless a finished result is waiting
   assign advance    = !rsp_valid || rsp_ready;
   assign last_issue = (ant_ff == ANT_LAST);
   assign issue_fire = hold_valid_ff && advance;
   // slot frees up on the cycle its last antenna goes into the pipeline
   assign req_ready  = (busy_ff == 2'd0) && (!hold_valid_ff || (advance && last_issue));
   assign req_fire   = req_valid && req_ready;

   always_comb begin
      // angle to turn units: round(|a| * 65536 / 360)
      steer_mag   = steer_ff[7] ? 8'(8'sd0 - steer_ff) : 8'(steer_ff);
      turn_num    = {steer_mag, 16'd0} + 24'd180;
      turn_prod   = 48'(turn_num) * 48'(RECIP_360);
      turn_signed = turn_neg_ff ? (16'd0 - turn_mag_ff) : turn_mag_ff;

      busy_in = busy_ff;
      if (steer_write) begin
         busy_in = STEER_SETTLE;
      end else if (busy_ff != 2'd0) begin
         busy_in = busy_ff - 2'd1;
      end

      hold_valid_in = hold_valid_ff;
      ant_in        = ant_ff;
      if (issue_fire) begin
         ant_in = last_issue ? 2'd0 : (ant_ff + 2'd1);
         if (last_issue) begin
            hold_valid_in = 1'b0;
         end
      end
      if (req_fire) begin
         hold_valid_in = 1'b1;
      end

      issue_data.ant      = ant_ff;
      issue_data.last     = last_issue;
      issue_data.cal      = cal_ff[ant_ff];
      issue_data.step     = step_ff[ant_ff];
      issue_data.sample_i = hold_i_ff;
      issue_data.sample_q = hold_q_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steer_ff      <= '0;
         turn_neg_ff   <= 1'b0;
         turn_mag_ff   <= '0;
         s_ang_ff      <= '0;
         busy_ff       <= '0;
         hold_valid_ff <= 1'b0;
         ant_ff        <= '0;
         for (int k = 0; k < NUM_CAL; k++) begin
            cal_ff[k]  <= '0;
            step_ff[k] <= '0;
         end
      end else begin
         if (csr_fire) begin
            unique case (csr_index) inside
               CSR_STEER_ANGLE: begin
                  steer_ff <= $signed(csr_data[7:0]);
               end
               [CSR_CAL_PHASE_0:CSR_CAL_PHASE_3]: begin
                  cal_ff[cal_sel[1:0]] <= csr_data;
               end
               default: begin
               end
            endcase
         end
         turn_neg_ff <= steer_ff[7];
         turn_mag_ff <= turn_prod[47:32];
         s_ang_ff    <= turn_sine(turn_signed);
         for (int k = 0; k < NUM_CAL; k++) begin
            step_ff[k] <= 16'(s_ang_ff[15:0] * 16'(k));
         end
         busy_ff       <= busy_in;
         hold_valid_ff <= hold_valid_in;
         ant_ff        <= ant_in;
      end
   end

   // sample payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         hold_i_ff <= req_sample_i;
         hold_q_ff <= req_sample_q;
      end
   end

   bspr_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .issue_valid      (hold_valid_ff),
      .issue_data       (issue_data),
      .rsp_valid        (rsp_valid),
      .rsp_antenna      (rsp_antenna),
      .rsp_out_i        (rsp_out_i),
      .rsp_out_q        (rsp_out_q),
      .rsp_clipped      (rsp_clipped),
      .rsp_last_antenna (rsp_last_antenna)
   );

   // an accepted transaction starts at antenna 0
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> hold_valid_ff && (ant_ff == 2'd0))
      else $error("accepted sample does not start at antenna 0");

   // steer write blocks new samples until the steps settle
   a_steer_settle: assert property (@(posedge clock) disable iff (reset)
      steer_write |=> (busy_ff == STEER_SETTLE) && !req_ready)
      else $error("sample path open during steer update");

   // stalled sequencer keeps its antenna
   a_ant_hold: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff && !advance |=> $stable(ant_ff) && hold_valid_ff)
      else $error("antenna sequencer moved during stall");

endmodule
